@@ rtl/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CpWidth      = 21;
   localparam int unsigned StatusWidth  = 2;
   localparam int unsigned PendWidth    = 2;
   localparam int unsigned PartialWidth = 15;

   localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_CODE = 2'd0,
      STATUS_REPL = 2'd1,
      STATUS_MALF = 2'd2,
      STATUS_END  = 2'd3
   } status_type;

   typedef struct packed {
      logic [PendWidth-1:0]    bytes_pending;
      logic [PartialWidth-1:0] partial_value;
   } dec_state_type;

   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] code_point;
      status_type         status;
   } dec_result_type;

endpackage

@@ rtl/u8d_if.sv @@
// Valid/ready channel interfaces for the byte input and the code point output.
`timescale 1ns / 1ps

interface u8d_byte_if;
   logic                          valid;
   logic                          ready;
   logic [u8d_pkg::ByteWidth-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
   logic                            valid;
   logic                            ready;
   logic [u8d_pkg::CpWidth-1:0]     code_point;
   logic [u8d_pkg::StatusWidth-1:0] status;

   modport source (output valid, output code_point, output status, input ready);
   modport sink   (input valid, input code_point, input status, output ready);
endinterface

@@ rtl/utf8_stream_decoder.sv @@
// Top level of the byte-serial UTF-8 stream decoder.
`timescale 1ns / 1ps

// One byte per transaction enters on req_chan; decoded code points leave on
// rsp_chan with a status (code point, replacement for a bad lead byte,
// malformed continuation, end of text). An accepted byte lands in the input
// register, and the decode logic writes its result to the result register
// once the result slot is free; a stalled sink holds it in the input register.
// One byte is taken every cycle while the input register is empty or the
// result register is empty or being drained; rate is set by the single
// decode step that reads and updates the sequence state. Lead and inner
// continuation bytes produce no result. A zero byte between sequences
// reports end of text and decoding carries on with the next byte.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   u8d_byte_if.sink    req_chan,
   u8d_cp_if.source    rsp_chan
);
   import u8d_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff, in_byte_in;

   // sequence state
   dec_state_type state_ff, state_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [CpWidth-1:0] out_cp_ff, out_cp_in;
   status_type         out_status_ff, out_status_in;

   dec_state_type  dec_state;
   dec_result_type dec_result;
   logic           out_free;
   logic           advance;

   u8d_decode u_decode (
      .state_cur (state_ff),
      .byte_cur  (in_byte_ff),
      .state_nxt (dec_state),
      .result    (dec_result)
   );

   // Result slot frees up when empty or when the sink takes it this cycle.
   assign out_free = !out_valid_ff || rsp_chan.ready;
   // Advance the buffered byte through decode whenever the slot is free.
   assign advance  = in_valid_ff && out_free;

   assign req_chan.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.in_byte;
      end
   end

   always_comb begin
      state_in      = state_ff;
      out_valid_in  = out_valid_ff;
      out_cp_in     = out_cp_ff;
      out_status_in = out_status_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         state_in     = dec_state;
         out_valid_in = dec_result.emit;
         if (dec_result.emit) begin
            out_cp_in     = dec_result.code_point;
            out_status_in = dec_result.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      out_cp_ff     <= out_cp_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.code_point = out_cp_ff;
   assign rsp_chan.status     = out_status_ff;

endmodule

@@ rtl/u8d_decode.sv @@
// Combinational decode of one byte against the current sequence state.
`timescale 1ns / 1ps

module u8d_decode (
   input  u8d_pkg::dec_state_type           state_cur,
   input  logic [u8d_pkg::ByteWidth-1:0]    byte_cur,
   output u8d_pkg::dec_state_type           state_nxt,
   output u8d_pkg::dec_result_type          result
);
   import u8d_pkg::*;

   logic is_cont;

   assign is_cont = (byte_cur[7:6] == 2'b10);

   always_comb begin
      state_nxt         = state_cur;
      result.emit       = 1'b0;
      result.code_point = '0;
      result.status     = STATUS_CODE;

      if (state_cur.bytes_pending != '0) begin
         if (!is_cont) begin
            // drop the byte, close the sequence
            state_nxt         = '0;
            result.emit       = 1'b1;
            result.status     = STATUS_MALF;
         end else if (state_cur.bytes_pending == 2'd1) begin
            state_nxt         = '0;
            result.emit       = 1'b1;
            result.code_point = {state_cur.partial_value, byte_cur[5:0]};
            result.status     = STATUS_CODE;
         end else begin
            state_nxt.partial_value = {state_cur.partial_value[PartialWidth-7:0],
                                       byte_cur[5:0]};
            state_nxt.bytes_pending = state_cur.bytes_pending - 2'd1;
         end
      end else if (byte_cur == '0) begin
         result.emit   = 1'b1;
         result.status = STATUS_END;
      end else if (!byte_cur[7]) begin
         result.emit       = 1'b1;
         result.code_point = {13'd0, byte_cur};
         result.status     = STATUS_CODE;
      end else if (byte_cur[7:5] == 3'b110) begin
         state_nxt.partial_value = {10'd0, byte_cur[4:0]};
         state_nxt.bytes_pending = 2'd1;
      end else if (byte_cur[7:4] == 4'b1110) begin
         state_nxt.partial_value = {11'd0, byte_cur[3:0]};
         state_nxt.bytes_pending = 2'd2;
      end else if (byte_cur[7:3] == 5'b11110) begin
         state_nxt.partial_value = {12'd0, byte_cur[2:0]};
         state_nxt.bytes_pending = 2'd3;
      end else begin
         result.emit       = 1'b1;
         result.code_point = ReplacementCp;
         result.status     = STATUS_REPL;
      end
   end

endmodule

@@ rtl/u8d_checker.sv @@
// Port-level assertions for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps

module u8d_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [u8d_pkg::CpWidth-1:0]     code_point,
   input logic [u8d_pkg::StatusWidth-1:0] status
);
   import u8d_pkg::*;

   // No result may be pending right after reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold the result stable while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_point) && $stable(status))
      else $error("stalled result changed");

   // A fresh result must trace back to an accepted input transaction.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching input transaction");

   // A bad lead byte always carries U+FFFD.
   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_REPL |-> code_point == ReplacementCp)
      else $error("replacement result with wrong code point");

   // End of text and malformed results carry a zero code point.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == STATUS_END || status == STATUS_MALF) |-> code_point == '0)
      else $error("end or malformed result with nonzero code point");

endmodule

bind utf8_stream_decoder u8d_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .code_point (rsp_chan.code_point),
   .status     (rsp_chan.status)
);
